[rtl/tdr_pkg.sv]
// shared constants and types for the tile deduplication block
package tdr_pkg;

  // one 2bpp tile is two 64-bit bitplanes
  localparam int PLANE_W = 64;
  localparam int TILE_W  = 2 * PLANE_W;

  // result field widths
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;

  // default depth of the distinct tile store
  localparam int MAX_TILES_DEF = 256;

  // control that travels with a tile along the compare chain
  typedef struct packed {
    logic valid;     // a tile is in this stage
    logic found;     // matched a stored tile upstream
    logic appended;  // stored as a new tile upstream
    logic last;      // last tile of the bank
  } tdr_ctl_t;

endpackage

[rtl/tile_dedup_remap.sv]
// top level of the tile deduplication block: compare chain and result control
//
//   channel  direction  ports
//   in_      input      in_valid, in_ready, in_plane_low, in_plane_high, in_last_tile
//   out_     output     out_valid, out_ready, out_new_index, out_is_new,
//                       out_distinct_count, out_full_error, out_last_out
//
// One tile is in flight at a time. It walks the row of MAX_TILES compare cells,
// one cell per cycle; its result then passes the pending register into the output
// register, and the next request is taken once that result leaves the pending register.
// With the full error latched a tile skips the row; its result fills the pending register.
// Reset clears the count, the error latch and all stage valids; the store needs no clearing.
// A stalled output holds one finished result in a pending register and no new request
// is taken until that result moves to the output register.
module tile_dedup_remap #(
  parameter int MAX_TILES = tdr_pkg::MAX_TILES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tdr_pkg::PLANE_W-1:0]          in_plane_low,
  input  logic [tdr_pkg::PLANE_W-1:0]          in_plane_high,
  input  logic                                 in_last_tile,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tdr_pkg::INDEX_W-1:0]          out_new_index,
  output logic                                 out_is_new,
  output logic [tdr_pkg::COUNT_W-1:0]          out_distinct_count,
  output logic                                 out_full_error,
  output logic                                 out_last_out
);

  localparam int IW = $clog2(MAX_TILES);
  localparam int CW = $clog2(MAX_TILES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TILES);

  // chain links, link 0 feeds the first cell and link MAX_TILES leaves the last
  tdr_pkg::tdr_ctl_t          link_ctl  [MAX_TILES+1];
  logic [tdr_pkg::TILE_W-1:0] link_tile [MAX_TILES+1];
  logic [IW-1:0]              link_idx  [MAX_TILES+1];

  logic          busy_r;
  logic          busy_nxt;
  logic [CW-1:0] total_r;
  logic [CW-1:0] total_nxt;
  logic          err_r;
  logic          err_nxt;

  logic          pend_valid_r;
  logic          pend_valid_nxt;
  logic [IW-1:0] pend_idx_r;
  logic [IW-1:0] pend_idx_nxt;
  logic          pend_new_r;
  logic          pend_new_nxt;
  logic [CW-1:0] pend_cnt_r;
  logic [CW-1:0] pend_cnt_nxt;
  logic          pend_err_r;
  logic          pend_err_nxt;
  logic          pend_last_r;
  logic          pend_last_nxt;

  logic                        out_valid_r;
  logic [tdr_pkg::INDEX_W-1:0] out_index_r;
  logic                        out_new_r;
  logic [tdr_pkg::COUNT_W-1:0] out_cnt_r;
  logic                        out_err_r;
  logic                        out_last_r;

  logic          accept;
  logic          out_free;
  logic          pend_move;
  tdr_pkg::tdr_ctl_t tail;
  logic          tail_hit;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign pend_move = pend_valid_r && out_free;
  assign in_ready  = !busy_r;

  // launch a search unless the error is latched
  assign link_ctl[0]  = '{valid: accept && !err_r, found: 1'b0, appended: 1'b0,
                          last: in_last_tile};
  assign link_tile[0] = {in_plane_high, in_plane_low};
  assign link_idx[0]  = '0;

  // row of compare cells
  for (genvar g = 0; g < MAX_TILES; g++) begin : g_cell
    tdr_cell #(
      .CELL_IDX (g),
      .IW       (IW),
      .CW       (CW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_in   (link_ctl[g]),
      .tile_in  (link_tile[g]),
      .idx_in   (link_idx[g]),
      .total    (total_r),
      .ctl_out  (link_ctl[g+1]),
      .tile_out (link_tile[g+1]),
      .idx_out  (link_idx[g+1])
    );
  end

  assign tail     = link_ctl[MAX_TILES];
  assign tail_hit = tail.found || tail.appended;

  // result forming, count and error latch updates
  always_comb begin
    busy_nxt       = busy_r;
    total_nxt      = total_r;
    err_nxt        = err_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    pend_new_nxt   = pend_new_r;
    pend_cnt_nxt   = pend_cnt_r;
    pend_err_nxt   = pend_err_r;
    pend_last_nxt  = pend_last_r;

    if (pend_move) begin
      pend_valid_nxt = 1'b0;
      busy_nxt       = 1'b0;
    end

    if (accept) begin
      busy_nxt = 1'b1;
    end

    if (accept && err_r) begin
      // latched error: no search, count unchanged
      pend_valid_nxt = 1'b1;
      pend_idx_nxt   = '0;
      pend_new_nxt   = 1'b0;
      pend_cnt_nxt   = total_r;
      pend_err_nxt   = 1'b1;
      pend_last_nxt  = in_last_tile;
      if (in_last_tile) begin
        total_nxt = '0;
        err_nxt   = 1'b0;
      end
    end else if (tail.valid) begin
      pend_valid_nxt = 1'b1;
      pend_idx_nxt   = tail_hit ? link_idx[MAX_TILES] : '0;
      pend_new_nxt   = tail.appended;
      pend_cnt_nxt   = tail.appended ? total_r + CW'(1) : total_r;
      pend_err_nxt   = !tail_hit;
      pend_last_nxt  = tail.last;
      if (tail.last) begin
        total_nxt = '0;
        err_nxt   = 1'b0;
      end else begin
        total_nxt = pend_cnt_nxt;
        err_nxt   = !tail_hit;
      end
    end
  end

  // control and pending result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      total_r      <= '0;
      err_r        <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      total_r      <= total_nxt;
      err_r        <= err_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
    pend_idx_r  <= pend_idx_nxt;
    pend_new_r  <= pend_new_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    pend_err_r  <= pend_err_nxt;
    pend_last_r <= pend_last_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= pend_valid_r;
    end
    if (pend_move) begin
      out_index_r <= tdr_pkg::INDEX_W'(pend_idx_r);
      out_new_r   <= pend_new_r;
      out_cnt_r   <= tdr_pkg::COUNT_W'(pend_cnt_r);
      out_err_r   <= pend_err_r;
      out_last_r  <= pend_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_new_index      = out_index_r;
  assign out_is_new         = out_new_r;
  assign out_distinct_count = out_cnt_r;
  assign out_full_error     = out_err_r;
  assign out_last_out       = out_last_r;

  // the count never passes the store depth
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= FULL_CNT)
    else $error("distinct count above store depth");

  // a tile leaving the row belongs to the request in flight
  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> busy_r)
    else $error("search result without a request in flight");

  // a pending result always belongs to the request in flight
  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> busy_r)
    else $error("pending result without a request in flight");

  // a tile that reaches the end of a row with free room is always placed
  a_room_placed: assert property (@(posedge clk) disable iff (!rst_n)
    (tail.valid && total_r < FULL_CNT) |-> tail_hit)
    else $error("tile dropped with room left in the store");

  // a new tile never carries the full error
  a_new_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_new_r && out_err_r))
    else $error("new tile flagged with full error");

endmodule

[rtl/tdr_cell.sv]
// one compare cell: holds one distinct tile and passes the search tile on
module tdr_cell #(
  parameter int CELL_IDX = 0,
  parameter int IW       = 8,
  parameter int CW       = 9
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tdr_pkg::tdr_ctl_t        ctl_in,
  input  logic [tdr_pkg::TILE_W-1:0] tile_in,
  input  logic [IW-1:0]            idx_in,
  input  logic [CW-1:0]            total,
  output tdr_pkg::tdr_ctl_t        ctl_out,
  output logic [tdr_pkg::TILE_W-1:0] tile_out,
  output logic [IW-1:0]            idx_out
);

  localparam logic [CW-1:0] MY_CNT = CW'(CELL_IDX);
  localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

  logic [tdr_pkg::TILE_W-1:0] entry_r;
  tdr_pkg::tdr_ctl_t          ctl_r;
  tdr_pkg::tdr_ctl_t          ctl_nxt;
  logic [tdr_pkg::TILE_W-1:0] tile_r;
  logic [IW-1:0]              idx_r;
  logic [IW-1:0]              idx_nxt;
  logic                       searching;
  logic                       hit;
  logic                       take;

  // compare against the stored entry, or claim this slot if it is the next free one
  assign searching = ctl_in.valid && !ctl_in.found && !ctl_in.appended;
  assign hit       = searching && (MY_CNT < total) && (entry_r == tile_in);
  assign take      = searching && (MY_CNT == total);

  always_comb begin
    ctl_nxt          = ctl_in;
    ctl_nxt.found    = ctl_in.found || hit;
    ctl_nxt.appended = ctl_in.appended || take;
    idx_nxt          = (hit || take) ? MY_IDX : idx_in;
  end

  // stored tile, written when a new tile lands in this slot
  always_ff @(posedge clk) begin
    if (take) begin
      entry_r <= tile_in;
    end
  end

  // stage register toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
    tile_r <= tile_in;
    idx_r  <= idx_nxt;
  end

  assign ctl_out  = ctl_r;
  assign tile_out = tile_r;
  assign idx_out  = idx_r;

endmodule
